// ----- hw/rtl/ocvm_pkg.sv -----
// ----------------------------------------------------------------------------
// ocvm_pkg
// Shared types, constants and tables for the orbit camera view matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package ocvm_pkg;

    // Angle limits, Q3.13
    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [17:0] PITCH_LO   = 18'sd4289;
    localparam logic signed [17:0] PITCH_HI   = 18'sd12868;

    // CORDIC constants, Q2.30
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // State reset values
    localparam logic signed [15:0] PITCH_RESET    = 16'sd4289;
    localparam logic signed [31:0] DISTANCE_RESET = 32'sd655360;
    localparam logic [30:0]        MIN_DIST_RESET = 31'd65536;
    localparam logic [30:0]        MAX_DIST_RESET = 31'd1310720;

    // Iteration count default and step index width (table has 24 entries)
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEP_W           = 5;

    // Register indexes
    localparam logic REG_MIN_DIST = 1'b0;
    localparam logic REG_MAX_DIST = 1'b1;

    // Multiply sequence: four rotation products, then nine dot-product terms
    localparam logic [3:0] OP_SPCT  = 4'd0;
    localparam logic [3:0] OP_SPST  = 4'd1;
    localparam logic [3:0] OP_CPCT  = 4'd2;
    localparam logic [3:0] OP_CPST  = 4'd3;
    localparam logic [3:0] OP_R0    = 4'd4;
    localparam logic [3:0] OP_R1    = 4'd5;
    localparam logic [3:0] OP_R2    = 4'd6;
    localparam logic [3:0] OP_U0    = 4'd7;
    localparam logic [3:0] OP_U1    = 4'd8;
    localparam logic [3:0] OP_U2    = 4'd9;
    localparam logic [3:0] OP_L0    = 4'd10;
    localparam logic [3:0] OP_L1    = 4'd11;
    localparam logic [3:0] OP_L2    = 4'd12;
    localparam logic [3:0] OP_LAST  = OP_L2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CINIT,
        ST_CSTEP,
        ST_CSAVE,
        ST_MUL,
        ST_TAKE,
        ST_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              cinit;
        logic              cstep;
        logic              csave;
        logic              sel_yaw;
        logic [STEP_W-1:0] idx;
        logic              mul_do;
        logic              take;
        logic [3:0]        op;
        logic              out_load;
    } ctrl_cmd_t;

    // arctan(2^-i) in Q2.30
    function automatic logic signed [34:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [34:0] r;
        case (i)
            5'd0:    r = 35'sd843314857;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043837;
            5'd3:    r = 35'sd133525159;
            5'd4:    r = 35'sd67021687;
            5'd5:    r = 35'sd33543516;
            5'd6:    r = 35'sd16775851;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194283;
            5'd9:    r = 35'sd2097149;
            5'd10:   r = 35'sd1048576;
            5'd11:   r = 35'sd524288;
            5'd12:   r = 35'sd262144;
            5'd13:   r = 35'sd131072;
            5'd14:   r = 35'sd65536;
            5'd15:   r = 35'sd32768;
            5'd16:   r = 35'sd16384;
            5'd17:   r = 35'sd8192;
            5'd18:   r = 35'sd4096;
            5'd19:   r = 35'sd2048;
            5'd20:   r = 35'sd1024;
            5'd21:   r = 35'sd512;
            5'd22:   r = 35'sd256;
            5'd23:   r = 35'sd128;
            default: r = 35'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ocvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ocvm_ctrl
// Sequencer: state update, two CORDIC runs, multiply sequence, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ocvm_ctrl #(
    parameter int CORDIC_STEPS = ocvm_pkg::CORDIC_STEPS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    output ocvm_pkg::ctrl_cmd_t   cmd
);
    import ocvm_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                sel_next   = 1'b0;
                state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                cnt_next   = '0;
                state_next = ST_CSTEP;
            end
            ST_CSTEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = ST_CSAVE;
            end
            ST_CSAVE:
            begin
                cnt_next = '0;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_CINIT;
                end
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_TAKE;
            ST_TAKE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[3:0] == OP_LAST)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.idx      = cnt_reg;
        cmd.op       = cnt_reg[3:0];
        cmd.sel_yaw  = sel_reg;
        in_ready     = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.cinit    = (state_reg == ST_CINIT);
        cmd.cstep    = (state_reg == ST_CSTEP);
        cmd.csave    = (state_reg == ST_CSAVE);
        cmd.mul_do   = (state_reg == ST_MUL);
        cmd.take     = (state_reg == ST_TAKE);
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ocvm_dp.sv -----
// ----------------------------------------------------------------------------
// ocvm_dp
// Datapath: camera state, shared CORDIC unit, shared multiplier, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ocvm_dp (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ocvm_pkg::ctrl_cmd_t  cmd,
    input  wire  [30:0]          min_distance,
    input  wire  [30:0]          max_distance,
    input  wire                  set_mode,
    input  wire  signed [15:0]   pitch_amount,
    input  wire  signed [15:0]   yaw_amount,
    input  wire  signed [31:0]   distance_amount,
    input  wire  signed [31:0]   target_x,
    input  wire  signed [31:0]   target_y,
    input  wire  signed [31:0]   target_z,
    output logic signed [15:0]   right_x,
    output logic signed [15:0]   up_x,
    output logic signed [15:0]   look_x,
    output logic signed [15:0]   right_y,
    output logic signed [15:0]   up_y,
    output logic signed [15:0]   look_y,
    output logic signed [15:0]   right_z,
    output logic signed [15:0]   up_z,
    output logic signed [15:0]   look_z,
    output logic signed [31:0]   shift_right,
    output logic signed [31:0]   shift_up,
    output logic signed [31:0]   shift_look
);
    import ocvm_pkg::*;

    // wrap an angle in [-58503, 58503] into [-pi, pi)
    function automatic logic signed [17:0] wrap18(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a >= PI_Q13)
            r = a - TWO_PI_Q13;
        else if (a < -PI_Q13)
            r = a + TWO_PI_Q13;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_pitch(input logic signed [17:0] p);
        logic signed [17:0] r;
        r = p;
        if (p < PITCH_LO)
            r = PITCH_LO;
        else if (p > PITCH_HI)
            r = PITCH_HI;
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] axis_out(input logic signed [31:0] v);
        logic signed [32:0] s;
        logic signed [16:0] r;
        s = {v[31], v} + 33'sd32768;
        r = s[32:16];
        if (r > 17'sd16384)
            r = 17'sd16384;
        else if (r < -17'sd16384)
            r = -17'sd16384;
        return r[15:0];
    endfunction

    // camera state
    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic signed [31:0] dist_reg, dist_next;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               cneg_reg;
    logic signed [31:0] cp_reg, sp_reg, ct_reg, st_reg;

    // products and dot accumulation
    logic signed [31:0] spct_reg, spst_reg, cpct_reg, cpst_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [31:0] sr_reg, su_reg, sl_reg;

    // state update
    always_comb
    begin
        logic signed [17:0] p, y;
        logic signed [32:0] nd;
        if (set_mode)
        begin
            p  = wrap18({{2{pitch_amount[15]}}, pitch_amount});
            y  = wrap18({{2{yaw_amount[15]}}, yaw_amount});
            nd = {distance_amount[31], distance_amount};
        end
        else
        begin
            p  = {{2{pitch_reg[15]}}, pitch_reg} - {{2{pitch_amount[15]}}, pitch_amount};
            y  = wrap18({{2{yaw_reg[15]}}, yaw_reg} - {{2{yaw_amount[15]}}, yaw_amount});
            nd = {dist_reg[31], dist_reg} + {distance_amount[31], distance_amount};
            if (nd < $signed({2'b00, min_distance}))
                nd = $signed({2'b00, min_distance});
            else if (nd > $signed({2'b00, max_distance}))
                nd = $signed({2'b00, max_distance});
        end
        pitch_next = clamp_pitch(p);
        yaw_next   = y[15:0];
        dist_next  = nd[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RESET;
            yaw_reg   <= '0;
            dist_reg  <= DISTANCE_RESET;
        end
        else if (cmd.load)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            dist_reg  <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_reg <= target_x;
            ty_reg <= target_y;
            tz_reg <= target_z;
        end
    end

    // CORDIC: fold into [-pi/2, pi/2], one rotation per cycle
    always_ff @(posedge clk)
    begin
        logic signed [15:0] a;
        logic signed [34:0] z;
        logic signed [33:0] dx, dy;
        a  = cmd.sel_yaw ? yaw_reg : pitch_reg;
        z  = {{2{a[15]}}, a, 17'd0};
        dx = cy_reg >>> cmd.idx;
        dy = cx_reg >>> cmd.idx;
        if (cmd.cinit)
        begin
            cx_reg <= GAIN_Q30;
            cy_reg <= '0;
            if (z > HALF_PI_Q30)
            begin
                cz_reg   <= z - PI_Q30;
                cneg_reg <= 1'b1;
            end
            else if (z < -HALF_PI_Q30)
            begin
                cz_reg   <= z + PI_Q30;
                cneg_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= z;
                cneg_reg <= 1'b0;
            end
        end
        else if (cmd.cstep)
        begin
            if (!cz_reg[34])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_q30(cmd.idx);
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_q30(cmd.idx);
            end
        end
        else if (cmd.csave)
        begin
            if (cmd.sel_yaw)
            begin
                ct_reg <= cneg_reg ? -cx_reg[31:0] : cx_reg[31:0];
                st_reg <= cneg_reg ? -cy_reg[31:0] : cy_reg[31:0];
            end
            else
            begin
                cp_reg <= cneg_reg ? -cx_reg[31:0] : cx_reg[31:0];
                sp_reg <= cneg_reg ? -cy_reg[31:0] : cy_reg[31:0];
            end
        end
    end

    // axis entries, Q2.30; right and look entries flip sign when distance is positive
    logic               dpos;
    logic signed [31:0] r0, r2, u0, u1, u2, l0, l1, l2;
    assign dpos = !dist_reg[31] && (dist_reg != '0);
    assign r0 = dpos ? -st_reg : st_reg;
    assign r2 = dpos ? ct_reg : -ct_reg;
    assign u0 = -cpct_reg;
    assign u1 = sp_reg;
    assign u2 = -cpst_reg;
    assign l0 = dpos ? -spct_reg : spct_reg;
    assign l1 = dpos ? -cp_reg : cp_reg;
    assign l2 = dpos ? -spst_reg : spst_reg;

    // multiplier operand select
    always_comb
    begin
        case (cmd.op)
            OP_SPCT: begin mul_a = sp_reg; mul_b = ct_reg; end
            OP_SPST: begin mul_a = sp_reg; mul_b = st_reg; end
            OP_CPCT: begin mul_a = cp_reg; mul_b = ct_reg; end
            OP_CPST: begin mul_a = cp_reg; mul_b = st_reg; end
            OP_R0:   begin mul_a = tx_reg; mul_b = r0;     end
            OP_R1:   begin mul_a = ty_reg; mul_b = '0;     end
            OP_R2:   begin mul_a = tz_reg; mul_b = r2;     end
            OP_U0:   begin mul_a = tx_reg; mul_b = u0;     end
            OP_U1:   begin mul_a = ty_reg; mul_b = u1;     end
            OP_U2:   begin mul_a = tz_reg; mul_b = u2;     end
            OP_L0:   begin mul_a = tx_reg; mul_b = l0;     end
            OP_L1:   begin mul_a = ty_reg; mul_b = l1;     end
            OP_L2:   begin mul_a = tz_reg; mul_b = l2;     end
            default: begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_do)
            prod_reg <= mul_a * mul_b;
    end

    // accumulate dot terms; the first term of each axis restarts the sum
    always_comb
    begin
        logic restart;
        restart  = (cmd.op == OP_R0) || (cmd.op == OP_U0) || (cmd.op == OP_L0);
        acc_next = (restart ? 66'sd0 : acc_reg) + {{2{prod_reg[63]}}, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        logic signed [33:0] pr;
        logic signed [65:0] ar;
        logic signed [37:0] sv;
        pr = 34'((prod_reg + 64'sd536870912) >>> 30);
        ar = (acc_next + 66'sd536870912) >>> 30;
        sv = -{{2{ar[35]}}, ar[35:0]};
        if (cmd.op == OP_L2)
            sv = sv + {{5{1'b0}}, (dist_reg[31] ? -{dist_reg[31], dist_reg}
                                                 : {dist_reg[31], dist_reg})};
        if (sv > 38'sd2147483647)
            sv = 38'sd2147483647;
        else if (sv < -38'sd2147483648)
            sv = -38'sd2147483648;
        if (cmd.take)
        begin
            acc_reg <= acc_next;
            case (cmd.op)
                OP_SPCT: spct_reg <= pr[31:0];
                OP_SPST: spst_reg <= pr[31:0];
                OP_CPCT: cpct_reg <= pr[31:0];
                OP_CPST: cpst_reg <= pr[31:0];
                OP_R2:   sr_reg   <= sv[31:0];
                OP_U2:   su_reg   <= sv[31:0];
                OP_L2:   sl_reg   <= sv[31:0];
                default: ;
            endcase
        end
    end

    // result registers; zero distance gives all zeros
    always_ff @(posedge clk)
    begin
        logic z;
        z = (dist_reg == '0);
        if (cmd.out_load)
        begin
            right_x     <= z ? '0 : axis_out(r0);
            right_y     <= '0;
            right_z     <= z ? '0 : axis_out(r2);
            up_x        <= z ? '0 : axis_out(u0);
            up_y        <= z ? '0 : axis_out(u1);
            up_z        <= z ? '0 : axis_out(u2);
            look_x      <= z ? '0 : axis_out(l0);
            look_y      <= z ? '0 : axis_out(l1);
            look_z      <= z ? '0 : axis_out(l2);
            shift_right <= z ? '0 : sr_reg;
            shift_up    <= z ? '0 : su_reg;
            shift_look  <= z ? '0 : sl_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/orbit_camera_view_matrix_core.sv -----
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix_core
// Orbit camera update and look-at view matrix, with APB limit registers.
// ----------------------------------------------------------------------------
// Each item takes two passes of one shared CORDIC unit, then 13 passes of one
// multiplier. A new item is accepted only after the previous result has been
// loaded into the result registers.
// Reset: pitch pi/6, yaw 0, distance 10.0, limits 1.0 and 20.0; no result held.
`default_nettype none

module orbit_camera_view_matrix_core #(
    parameter int CORDIC_STEPS = ocvm_pkg::CORDIC_STEPS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                set_mode,
    input  wire  signed [15:0] pitch_amount,
    input  wire  signed [15:0] yaw_amount,
    input  wire  signed [31:0] distance_amount,
    input  wire  signed [31:0] target_x,
    input  wire  signed [31:0] target_y,
    input  wire  signed [31:0] target_z,
    // result items
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [15:0] right_x,
    output logic signed [15:0] up_x,
    output logic signed [15:0] look_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] up_y,
    output logic signed [15:0] look_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_z,
    output logic signed [15:0] look_z,
    output logic signed [31:0] shift_right,
    output logic signed [31:0] shift_up,
    output logic signed [31:0] shift_look
);
    import ocvm_pkg::*;

    logic [30:0] min_dist_reg, max_dist_reg;
    ctrl_cmd_t   cmd;

    // limit registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RESET;
            max_dist_reg <= MAX_DIST_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_MIN_DIST)
                min_dist_reg <= pwdata[30:0];
            else
                max_dist_reg <= pwdata[30:0];
        end
    end

    assign prdata = {1'b0, (paddr[2] == REG_MAX_DIST) ? max_dist_reg : min_dist_reg};

    ocvm_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    ocvm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .min_distance   (min_dist_reg),
        .max_distance   (max_dist_reg),
        .set_mode       (set_mode),
        .pitch_amount   (pitch_amount),
        .yaw_amount     (yaw_amount),
        .distance_amount(distance_amount),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_z       (target_z),
        .right_x        (right_x),
        .up_x           (up_x),
        .look_x         (look_x),
        .right_y        (right_y),
        .up_y           (up_y),
        .look_y         (look_y),
        .right_z        (right_z),
        .up_z           (up_z),
        .look_z         (look_z),
        .shift_right    (shift_right),
        .shift_up       (shift_up),
        .shift_look     (shift_look)
    );

endmodule

`default_nettype wire
